/* rtl/core/ising_metropolis_flip_engine_assert.svh */
// Assertion macros shared by the Ising flip engine RTL.
// No dependencies; compiled to nothing when SYNTH is defined.
`ifndef ISING_METROPOLIS_FLIP_ENGINE_ASSERT_SVH
`define ISING_METROPOLIS_FLIP_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define IME_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ising flip engine check failed");
// Next-cycle implication.
`define IME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ising flip engine check failed");
`else
`define IME_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define IME_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/ime_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Ising Metropolis flip engine.
// No dependencies; every other file of the block but the assertion header refers to it by scope.
package ime_pkg;

   localparam int SIDE_DEFAULT      = 64;
   localparam int DRAW_BITS_DEFAULT = 16;

   localparam int X_W        = 6;
   localparam int DRAW_W     = 16;
   localparam int THR_W      = 16;
   localparam int H_W        = 11;
   localparam int M_OUT_W    = 14;
   localparam int E_OUT_W    = 24;
   localparam int STEP_W     = 32;
   localparam int FRAC_BITS  = 8;
   localparam int IDX_MAX_W  = 8;

   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_IDX_LSB = 3;
   localparam int REG_IDX_W   = CSR_ADDR_W - REG_IDX_LSB;

   localparam logic [REG_IDX_W-1:0] REG_TABLE_LOW  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TABLE_MID  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TABLE_HIGH = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FIELD_H    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOWER_M    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_UPPER_M    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_MAX_STEPS  = 3'd6;

   typedef enum logic [1:0] {
      ACT_FORCE   = 2'd0,
      ACT_PROPOSE = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      OUT_RUNNING = 2'd0,
      OUT_LOWER   = 2'd1,
      OUT_UPPER   = 2'd2,
      OUT_LIMIT   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [63:0]            table_low;
      logic [63:0]            table_mid;
      logic [31:0]            table_high;
      logic signed [H_W-1:0]  field_h;
      logic signed [M_OUT_W-1:0] lower_m;
      logic signed [M_OUT_W-1:0] upper_m;
      logic [STEP_W-1:0]      max_steps;
   } csr_type;

   localparam csr_type CSR_RESET = '{
      table_low:  64'd0,
      table_mid:  64'd0,
      table_high: 32'd0,
      field_h:    11'sd0,
      lower_m:    -14'sd4097,
      upper_m:    14'sd4097,
      max_steps:  32'd0
   };

   typedef struct packed {
      action_type        action;
      logic              spin_value;
      logic [DRAW_W-1:0] random_draw;
   } item_type;

   typedef struct packed {
      logic              accepted;
      logic [STEP_W-1:0] steps;
   } flip_res_type;

   // Reduces a site index modulo the lattice side by restoring subtraction of
   // the side times eight, four, two and one; the index is under 64.
   function automatic logic [IDX_MAX_W-1:0] side_mod(input logic [X_W-1:0] v,
                                                     input int side);
      logic [X_W-1:0] rem;
      rem = v;
      for (int k = 3; k >= 0; k--) begin
         if (int'(rem) >= (side << k)) begin
            rem = rem - X_W'(side << k);
         end
      end
      return IDX_MAX_W'(rem);
   endfunction

endpackage

/* rtl/core/ime_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for proposal beats and result beats.
// Depends on ime_pkg for field widths.
interface ime_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  action;
   logic [ime_pkg::X_W-1:0]     x_index;
   logic [ime_pkg::X_W-1:0]     y_index;
   logic                        spin_value;
   logic [ime_pkg::DRAW_W-1:0]  random_draw;

   modport source(output valid, action, x_index, y_index, spin_value, random_draw,
                  input ready);
   modport sink(input valid, action, x_index, y_index, spin_value, random_draw,
                output ready);
endinterface

interface ime_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               accepted;
   logic signed [ime_pkg::M_OUT_W-1:0] magnetization;
   logic signed [ime_pkg::E_OUT_W-1:0] energy;
   logic [ime_pkg::STEP_W-1:0]         step_count;
   logic [1:0]                         outcome;

   modport source(output valid, accepted, magnetization, energy, step_count, outcome,
                  input ready);
   modport sink(input valid, accepted, magnetization, energy, step_count, outcome,
                output ready);
endinterface

/* rtl/core/ime_csr.sv */
`timescale 1ns / 1ps
// APB-style register file holding the threshold table, field and run limits.
// Depends on ime_pkg.
module ime_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ime_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ime_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ime_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output ime_pkg::csr_type                  cfg
);

   ime_pkg::csr_type                  cfg_ff, cfg_in;
   logic [ime_pkg::REG_IDX_W-1:0]     reg_idx;
   logic                              write_hit;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ime_pkg::CSR_ADDR_W-1:ime_pkg::REG_IDX_LSB];
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         case (reg_idx)
            ime_pkg::REG_TABLE_LOW:  cfg_in.table_low  = csr_pwdata;
            ime_pkg::REG_TABLE_MID:  cfg_in.table_mid  = csr_pwdata;
            ime_pkg::REG_TABLE_HIGH: cfg_in.table_high = csr_pwdata[31:0];
            ime_pkg::REG_FIELD_H:    cfg_in.field_h    = csr_pwdata[ime_pkg::H_W-1:0];
            ime_pkg::REG_LOWER_M:    cfg_in.lower_m    = csr_pwdata[ime_pkg::M_OUT_W-1:0];
            ime_pkg::REG_UPPER_M:    cfg_in.upper_m    = csr_pwdata[ime_pkg::M_OUT_W-1:0];
            ime_pkg::REG_MAX_STEPS:  cfg_in.max_steps  = csr_pwdata[ime_pkg::STEP_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ime_pkg::REG_TABLE_LOW:  csr_prdata = cfg_ff.table_low;
         ime_pkg::REG_TABLE_MID:  csr_prdata = cfg_ff.table_mid;
         ime_pkg::REG_TABLE_HIGH: csr_prdata = {32'd0, cfg_ff.table_high};
         ime_pkg::REG_FIELD_H:
            csr_prdata = {{(ime_pkg::CSR_DATA_W-ime_pkg::H_W){1'b0}}, cfg_ff.field_h};
         ime_pkg::REG_LOWER_M:
            csr_prdata = {{(ime_pkg::CSR_DATA_W-ime_pkg::M_OUT_W){1'b0}}, cfg_ff.lower_m};
         ime_pkg::REG_UPPER_M:
            csr_prdata = {{(ime_pkg::CSR_DATA_W-ime_pkg::M_OUT_W){1'b0}}, cfg_ff.upper_m};
         ime_pkg::REG_MAX_STEPS:  csr_prdata = {32'd0, cfg_ff.max_steps};
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ime_pkg::CSR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/ime_lattice.sv */
`timescale 1ns / 1ps
// Spin lattice store: three row-wide copies, one read port each, with row
// valid bits and forwarding of the most recent row write. Depends on ime_pkg.
module ime_lattice #(
   parameter int SIDE  = ime_pkg::SIDE_DEFAULT,
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_row_up,
   input  logic [IDX_W-1:0] rd_row_mid,
   input  logic [IDX_W-1:0] rd_row_dn,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_row,
   input  logic [SIDE-1:0]  wr_data,
   output logic [SIDE-1:0]  row_up,
   output logic [SIDE-1:0]  row_mid,
   output logic [SIDE-1:0]  row_dn
);

   // Each copy holds the whole lattice so that three rows can be read at once.
   logic [SIDE-1:0]  up_mem  [SIDE];
   logic [SIDE-1:0]  mid_mem [SIDE];
   logic [SIDE-1:0]  dn_mem  [SIDE];

   logic [SIDE-1:0]  up_data_ff, mid_data_ff, dn_data_ff;
   logic [IDX_W-1:0] up_addr_ff, mid_addr_ff, dn_addr_ff;
   logic [IDX_W-1:0] up_addr_in, mid_addr_in, dn_addr_in;
   logic             up_live_ff, mid_live_ff, dn_live_ff;
   logic             up_live_in, mid_live_in, dn_live_in;

   // A row never written reads as all spins down.
   logic [SIDE-1:0]  row_valid_ff, row_valid_in;

   logic             wr_valid_ff, wr_valid_in;
   logic [IDX_W-1:0] wr_row_ff, wr_row_in;
   logic [SIDE-1:0]  wr_data_ff, wr_data_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         up_mem[wr_row]  <= wr_data;
         mid_mem[wr_row] <= wr_data;
         dn_mem[wr_row]  <= wr_data;
      end
      if (rd_en) begin
         up_data_ff  <= up_mem[rd_row_up];
         mid_data_ff <= mid_mem[rd_row_mid];
         dn_data_ff  <= dn_mem[rd_row_dn];
      end
   end

   always_comb begin
      up_addr_in   = up_addr_ff;
      mid_addr_in  = mid_addr_ff;
      dn_addr_in   = dn_addr_ff;
      up_live_in   = up_live_ff;
      mid_live_in  = mid_live_ff;
      dn_live_in   = dn_live_ff;
      row_valid_in = row_valid_ff;
      wr_valid_in  = wr_valid_ff;
      wr_row_in    = wr_row_ff;
      wr_data_in   = wr_data_ff;
      if (rd_en) begin
         up_addr_in  = rd_row_up;
         mid_addr_in = rd_row_mid;
         dn_addr_in  = rd_row_dn;
         up_live_in  = row_valid_ff[rd_row_up];
         mid_live_in = row_valid_ff[rd_row_mid];
         dn_live_in  = row_valid_ff[rd_row_dn];
      end
      if (wr_en) begin
         row_valid_in[wr_row] = 1'b1;
         wr_valid_in          = 1'b1;
         wr_row_in            = wr_row;
         wr_data_in           = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         wr_valid_ff  <= 1'b0;
         up_live_ff   <= 1'b0;
         mid_live_ff  <= 1'b0;
         dn_live_ff   <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         wr_valid_ff  <= wr_valid_in;
         up_live_ff   <= up_live_in;
         mid_live_ff  <= mid_live_in;
         dn_live_ff   <= dn_live_in;
      end
      up_addr_ff  <= up_addr_in;
      mid_addr_ff <= mid_addr_in;
      dn_addr_ff  <= dn_addr_in;
      wr_row_ff   <= wr_row_in;
      wr_data_ff  <= wr_data_in;
   end

   // The last row written is always the current content of that row, so it
   // covers a write landing on the same edge as the read.
   always_comb begin
      if (wr_valid_ff && (wr_row_ff == up_addr_ff)) begin
         row_up = wr_data_ff;
      end else begin
         row_up = up_live_ff ? up_data_ff : '0;
      end
      if (wr_valid_ff && (wr_row_ff == mid_addr_ff)) begin
         row_mid = wr_data_ff;
      end else begin
         row_mid = mid_live_ff ? mid_data_ff : '0;
      end
      if (wr_valid_ff && (wr_row_ff == dn_addr_ff)) begin
         row_dn = wr_data_ff;
      end else begin
         row_dn = dn_live_ff ? dn_data_ff : '0;
      end
   end

endmodule

/* rtl/core/ime_flip.sv */
`timescale 1ns / 1ps
// Flip decision and running totals (magnetization, bond sum, step count).
// Depends on ime_pkg and the assertion macro header.
`include "ising_metropolis_flip_engine_assert.svh"
module ime_flip #(
   parameter int SIDE      = ime_pkg::SIDE_DEFAULT,
   parameter int DRAW_BITS = ime_pkg::DRAW_BITS_DEFAULT,
   parameter int IDX_W     = 6,
   parameter int MW        = 14,
   parameter int BW        = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ime_pkg::item_type     item,
   input  logic [IDX_W-1:0]      x_row,
   input  logic [IDX_W-1:0]      y_col,
   input  logic [SIDE-1:0]       row_up,
   input  logic [SIDE-1:0]       row_mid,
   input  logic [SIDE-1:0]       row_dn,
   input  ime_pkg::csr_type      cfg,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_row,
   output logic [SIDE-1:0]       wr_data,
   output ime_pkg::flip_res_type res,
   output logic signed [MW-1:0]  m_next,
   output logic signed [BW-1:0]  b_next
);

   localparam int CMP_BITS = (DRAW_BITS < ime_pkg::DRAW_W) ? DRAW_BITS : ime_pkg::DRAW_W;
   localparam logic [ime_pkg::DRAW_W-1:0] DRAW_MASK =
      ime_pkg::DRAW_W'((64'd1 << CMP_BITS) - 64'd1);
   localparam int FT_W = 14;

   function automatic logic [ime_pkg::THR_W-1:0] pick_threshold(
      input ime_pkg::csr_type c, input logic [3:0] idx);
      logic [ime_pkg::THR_W-1:0] t;
      case (idx)
         4'd0:    t = c.table_low[15:0];
         4'd1:    t = c.table_low[31:16];
         4'd2:    t = c.table_low[47:32];
         4'd3:    t = c.table_low[63:48];
         4'd4:    t = c.table_mid[15:0];
         4'd5:    t = c.table_mid[31:16];
         4'd6:    t = c.table_mid[47:32];
         4'd7:    t = c.table_mid[63:48];
         4'd8:    t = c.table_high[15:0];
         4'd9:    t = c.table_high[31:16];
         default: t = '0;
      endcase
      return t;
   endfunction

   logic signed [MW-1:0]          m_ff, m_in;
   logic signed [BW-1:0]          b_ff, b_in;
   logic [ime_pkg::STEP_W-1:0]    steps_ff, steps_in;

   logic [IDX_W-1:0]              y_m, y_p;
   logic                          old_spin;
   logic [2:0]                    up_count;
   logic signed [4:0]             nsum;
   logic signed [FT_W-1:0]        field_term;
   logic                          cost_ok;
   logic [3:0]                    tbl_idx;
   logic [ime_pkg::THR_W-1:0]     thr;
   logic [ime_pkg::DRAW_W-1:0]    draw_cut;
   logic                          take;
   logic                          flip;
   logic signed [BW-1:0]          bond_step;

   always_comb begin
      y_m      = (y_col == '0) ? IDX_W'(SIDE - 1) : y_col - 1'b1;
      y_p      = (y_col == IDX_W'(SIDE - 1)) ? '0 : y_col + 1'b1;
      old_spin = row_mid[y_col];
      up_count = 3'(row_up[y_col]) + 3'(row_dn[y_col]) + 3'(row_mid[y_m])
               + 3'(row_mid[y_p]);
      // Four neighbours at plus or minus one give 2*ups - 4.
      nsum       = signed'({1'b0, up_count, 1'b0}) - 5'sd4;
      field_term = (FT_W'(nsum) <<< ime_pkg::FRAC_BITS) + FT_W'(cfg.field_h);
      cost_ok    = old_spin ? (field_term <= 14'sd0) : (field_term >= 14'sd0);
      tbl_idx    = old_spin ? 4'(up_count) + 4'd5 : 4'(up_count);
      thr        = pick_threshold(cfg, tbl_idx);
      draw_cut   = item.random_draw & DRAW_MASK;
      take       = cost_ok || (draw_cut < thr);
      bond_step  = BW'(nsum) <<< 1;
   end

   always_comb begin
      flip     = 1'b0;
      steps_in = steps_ff;
      case (item.action)
         ime_pkg::ACT_FORCE: begin
            flip = (old_spin != item.spin_value);
         end
         ime_pkg::ACT_PROPOSE: begin
            flip = take;
            if (take && (steps_ff != '1)) begin
               steps_in = steps_ff + 1'b1;
            end
         end
         ime_pkg::ACT_CLEAR: begin
            steps_in = '0;
         end
         default: begin
            flip     = 1'b0;
            steps_in = steps_ff;
         end
      endcase
      m_in = m_ff;
      b_in = b_ff;
      if (flip) begin
         m_in = old_spin ? m_ff - MW'(2) : m_ff + MW'(2);
         b_in = old_spin ? b_ff - bond_step : b_ff + bond_step;
      end
   end

   assign wr_en        = fire && flip;
   assign wr_row       = x_row;
   assign wr_data      = row_mid ^ ({{(SIDE-1){1'b0}}, 1'b1} << y_col);
   assign res.accepted = flip;
   assign res.steps    = steps_in;
   assign m_next       = m_in;
   assign b_next       = b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff     <= MW'(-(SIDE * SIDE));
         b_ff     <= BW'(2 * SIDE * SIDE);
         steps_ff <= '0;
      end else if (fire) begin
         m_ff     <= m_in;
         b_ff     <= b_in;
         steps_ff <= steps_in;
      end
   end

   `IME_ASSERT_NEXT(a_clear_zeroes_steps, clock, reset,
      fire && (item.action == ime_pkg::ACT_CLEAR), steps_ff == '0)
   `IME_ASSERT_NEXT(a_idle_keeps_totals, clock, reset,
      !fire, $stable(m_ff) && $stable(b_ff) && $stable(steps_ff))
   `IME_ASSERT_NEXT(a_write_moves_m, clock, reset,
      wr_en, m_ff != $past(m_ff))

endmodule

/* rtl/core/ime_result.sv */
`timescale 1ns / 1ps
// Result register with energy and run-outcome evaluation on the result beat.
// Depends on ime_pkg and the ime_rsp_if interface.
module ime_result #(
   parameter int MW = 14,
   parameter int BW = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ime_pkg::flip_res_type res,
   input  logic signed [MW-1:0]  m_next,
   input  logic signed [BW-1:0]  b_next,
   input  ime_pkg::csr_type      cfg,
   output logic                  free,
   ime_rsp_if.source             rsp_ch
);

   localparam int EW0 = (BW + ime_pkg::FRAC_BITS + 1 > MW + ime_pkg::H_W + 1)
                      ? BW + ime_pkg::FRAC_BITS + 1 : MW + ime_pkg::H_W + 1;
   localparam int EW  = (EW0 > ime_pkg::E_OUT_W) ? EW0 : ime_pkg::E_OUT_W;
   localparam int CW  = (MW > ime_pkg::M_OUT_W) ? MW : ime_pkg::M_OUT_W;

   logic                           out_valid_ff, out_valid_in;
   ime_pkg::flip_res_type          out_res_ff;
   logic signed [MW-1:0]           out_m_ff;
   logic signed [BW-1:0]           out_b_ff;

   logic signed [ime_pkg::H_W+MW-1:0] field_prod;
   logic signed [EW-1:0]              energy_wide;
   logic signed [CW-1:0]              m_cmp, lower_cmp, upper_cmp;
   ime_pkg::outcome_type              outcome;

   assign free         = !out_valid_ff || rsp_ch.ready;
   assign out_valid_in = load || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         out_res_ff <= res;
         out_m_ff   <= m_next;
         out_b_ff   <= b_next;
      end
   end

   assign field_prod  = cfg.field_h * out_m_ff;
   assign energy_wide = -(EW'(out_b_ff) <<< ime_pkg::FRAC_BITS) - EW'(field_prod);

   assign m_cmp     = CW'(out_m_ff);
   assign lower_cmp = CW'(cfg.lower_m);
   assign upper_cmp = CW'(cfg.upper_m);

   always_comb begin
      outcome = ime_pkg::OUT_RUNNING;
      if (cfg.max_steps != '0) begin
         if (out_res_ff.steps >= cfg.max_steps) begin
            outcome = ime_pkg::OUT_LIMIT;
         end
      end else if (m_cmp == lower_cmp) begin
         outcome = ime_pkg::OUT_LOWER;
      end else if (m_cmp == upper_cmp) begin
         outcome = ime_pkg::OUT_UPPER;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.accepted      = out_res_ff.accepted;
   assign rsp_ch.magnetization = ime_pkg::M_OUT_W'(out_m_ff);
   assign rsp_ch.energy        = ime_pkg::E_OUT_W'(energy_wide);
   assign rsp_ch.step_count    = out_res_ff.steps;
   assign rsp_ch.outcome       = outcome;

endmodule

/* rtl/core/ising_metropolis_flip_engine.sv */
`timescale 1ns / 1ps
// Top level of the Ising Metropolis single-spin-flip engine.
// Depends on ime_pkg, ime_if, ime_csr, ime_lattice, ime_flip, ime_result and the assertion header.
//
//   port group | direction | beat carries
//   req_ch     | in        | action, site row and column, forced spin, draw
//   rsp_ch     | out       | accepted, magnetization, energy, step count, outcome
//   csr_*      | in/out    | APB writes and reads of the seven registers
//
// One proposal beat is taken every cycle unless the request side stalls; its
// result beat passes the lattice read register, then the result register.
// The rate is set by the three lattice row copies, each read once per cycle.
// After reset all rows read as spins down through row valid bits; no sweep.
// A stalled result holds the flip stage, and the request side stalls only
// when both the flip stage and the result register are occupied.
`include "ising_metropolis_flip_engine_assert.svh"
module ising_metropolis_flip_engine #(
   parameter int SIDE      = ime_pkg::SIDE_DEFAULT,
   parameter int DRAW_BITS = ime_pkg::DRAW_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   ime_req_if.sink                        req_ch,
   ime_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ime_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ime_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ime_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int IDX_W = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int MW    = $clog2(SIDE * SIDE) + 2;
   localparam int BW    = $clog2(2 * SIDE * SIDE) + 2;

   ime_pkg::csr_type              cfg;

   logic                          req_accept;
   logic                          s1_fire;
   logic                          out_free;

   logic                          s1_valid_ff, s1_valid_in;
   ime_pkg::item_type             s1_item_ff;
   logic [IDX_W-1:0]              s1_x_ff, s1_y_ff;

   logic [ime_pkg::IDX_MAX_W-1:0] x_full, y_full;
   logic [IDX_W-1:0]              x_mod, y_mod, x_up, x_dn;

   logic [SIDE-1:0]               row_up, row_mid, row_dn;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_row;
   logic [SIDE-1:0]               wr_data;
   ime_pkg::flip_res_type         flip_res;
   logic signed [MW-1:0]          m_next;
   logic signed [BW-1:0]          b_next;

   assign s1_fire      = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);

   assign x_full = ime_pkg::side_mod(req_ch.x_index, SIDE);
   assign y_full = ime_pkg::side_mod(req_ch.y_index, SIDE);
   assign x_mod  = x_full[IDX_W-1:0];
   assign y_mod  = y_full[IDX_W-1:0];
   assign x_up   = (x_mod == '0) ? IDX_W'(SIDE - 1) : x_mod - 1'b1;
   assign x_dn   = (x_mod == IDX_W'(SIDE - 1)) ? '0 : x_mod + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_item_ff.action      <= ime_pkg::action_type'(req_ch.action);
         s1_item_ff.spin_value  <= req_ch.spin_value;
         s1_item_ff.random_draw <= req_ch.random_draw;
         s1_x_ff                <= x_mod;
         s1_y_ff                <= y_mod;
      end
   end

   ime_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ime_lattice #(
      .SIDE  (SIDE),
      .IDX_W (IDX_W)
   ) u_lattice (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_accept),
      .rd_row_up  (x_up),
      .rd_row_mid (x_mod),
      .rd_row_dn  (x_dn),
      .wr_en      (wr_en),
      .wr_row     (wr_row),
      .wr_data    (wr_data),
      .row_up     (row_up),
      .row_mid    (row_mid),
      .row_dn     (row_dn)
   );

   ime_flip #(
      .SIDE      (SIDE),
      .DRAW_BITS (DRAW_BITS),
      .IDX_W     (IDX_W),
      .MW        (MW),
      .BW        (BW)
   ) u_flip (
      .clock   (clock),
      .reset   (reset),
      .fire    (s1_fire),
      .item    (s1_item_ff),
      .x_row   (s1_x_ff),
      .y_col   (s1_y_ff),
      .row_up  (row_up),
      .row_mid (row_mid),
      .row_dn  (row_dn),
      .cfg     (cfg),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_data (wr_data),
      .res     (flip_res),
      .m_next  (m_next),
      .b_next  (b_next)
   );

   ime_result #(
      .MW (MW),
      .BW (BW)
   ) u_result (
      .clock  (clock),
      .reset  (reset),
      .load   (s1_fire),
      .res    (flip_res),
      .m_next (m_next),
      .b_next (b_next),
      .cfg    (cfg),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

   `IME_ASSERT_HOLDS(a_stall_blocks_accept, clock, reset,
      s1_valid_ff && !s1_fire, !req_accept)
   `IME_ASSERT_NEXT(a_accept_fills_stage, clock, reset,
      req_accept, s1_valid_ff)
   `IME_ASSERT_NEXT(a_stall_holds_site, clock, reset,
      s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_x_ff) && $stable(s1_y_ff))

endmodule
